// ===== src/pdc_pkg.sv =====
// ----------------------------------------------------------------------------
// PWM duty-cycle capture package
// Shared constants for the edge front end, the job queue and the divider.
// ----------------------------------------------------------------------------
package pdc_pkg;

  // default configuration
  localparam int FRAC_BITS_DEF  = 16;
  localparam int TIMER_BITS_DEF = 16;

  // job queue depth between front and back
  localparam int QUEUE_DEPTH = 2;

  // quotient width, and saturation value of the duty word
  localparam int          DUTY_BITS = 16;
  localparam logic [15:0] DUTY_MAX  = 16'hFFFF;

  // timestamp reset values
  localparam int RISE_RESET = 2;
  localparam int FALL_RESET = 1;

endpackage

// ===== src/pdc_if.sv =====
// ----------------------------------------------------------------------------
// PWM duty-cycle capture channels
// Valid/ready channels for edge timestamps in and duty results out.
// ----------------------------------------------------------------------------
interface pdc_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] capture_time;

  modport source (output valid, output capture_time, input ready);
  modport sink   (input valid, input capture_time, output ready);
endinterface

interface pdc_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] duty_fraction;
  logic [15:0] period_ticks;
  logic        divide_error;

  modport source (output valid, output duty_fraction, output period_ticks,
                  output divide_error, input ready);
  modport sink   (input valid, input duty_fraction, input period_ticks,
                  input divide_error, output ready);
endinterface

// ===== src/pdc_front.sv =====
// ----------------------------------------------------------------------------
// PWM duty-cycle capture front end
// Tracks rising/falling phase, keeps edge timestamps and queues one job
// (period, high time) per rising edge.
// ----------------------------------------------------------------------------
module pdc_front
  import pdc_pkg::*;
#(
  parameter int TIMER_BITS = TIMER_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  pdc_in_if.sink                  capture,
  output logic                    push_valid,
  output logic [2*TIMER_BITS-1:0] push_data,
  input  logic                    push_ready
);

  logic                  expect_rising;
  logic [TIMER_BITS-1:0] previous_rise_time;
  logic [TIMER_BITS-1:0] fall_time;

  logic [TIMER_BITS+15:0] capture_ext;
  logic [TIMER_BITS-1:0]  now;
  logic [TIMER_BITS-1:0]  period;
  logic [TIMER_BITS-1:0]  high_time;
  logic                   accept;

  // timestamp masked/extended to timer width
  assign capture_ext = {{TIMER_BITS{1'b0}}, capture.capture_time};
  assign now         = capture_ext[TIMER_BITS-1:0];

  // down-counter: earlier edge minus later edge, wraps naturally
  assign period    = previous_rise_time - now;
  assign high_time = previous_rise_time - fall_time;

  // falling edges need no queue slot
  assign capture.ready = expect_rising ? push_ready : 1'b1;
  assign accept        = capture.valid && capture.ready;

  assign push_valid = capture.valid && expect_rising;
  assign push_data  = {period, high_time};

  // edge phase and timestamps
  always_ff @(posedge clk) begin
    if (rst) begin
      expect_rising      <= 1'b1;
      previous_rise_time <= TIMER_BITS'(RISE_RESET);
      fall_time          <= TIMER_BITS'(FALL_RESET);
    end else if (accept) begin
      if (expect_rising) begin
        previous_rise_time <= now;
        expect_rising      <= 1'b0;
      end else begin
        fall_time     <= now;
        expect_rising <= 1'b1;
      end
    end
  end

endmodule

// ===== src/pdc_queue.sv =====
// ----------------------------------------------------------------------------
// PWM duty-cycle capture job queue
// Small register FIFO between the edge front end and the divider.
// ----------------------------------------------------------------------------
module pdc_queue
  import pdc_pkg::*;
#(
  parameter int WIDTH = 2 * TIMER_BITS_DEF,
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  input  logic [WIDTH-1:0] push_data,
  output logic             push_ready,
  output logic             pop_valid,
  output logic [WIDTH-1:0] pop_data,
  input  logic             pop_ready
);

  localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_BITS = $clog2(DEPTH + 1);

  logic [WIDTH-1:0]    entries [DEPTH];
  logic [PTR_BITS-1:0] wr_ptr;
  logic [PTR_BITS-1:0] rd_ptr;
  logic [CNT_BITS-1:0] count;
  logic                do_push;
  logic                do_pop;

  assign push_ready = (count != CNT_BITS'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== src/pdc_back.sv =====
// ----------------------------------------------------------------------------
// PWM duty-cycle capture back end
// Restoring divider, one quotient bit per cycle, with zero-period and
// saturation checks up front and a registered result word.
// ----------------------------------------------------------------------------
module pdc_back
  import pdc_pkg::*;
#(
  parameter int FRAC_BITS  = FRAC_BITS_DEF,
  parameter int TIMER_BITS = TIMER_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    pop_valid,
  input  logic [2*TIMER_BITS-1:0] pop_data,
  output logic                    pop_ready,
  pdc_out_if.source               result
);

  localparam int CNT_BITS = $clog2(DUTY_BITS);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV  = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0] state;

  logic [TIMER_BITS-1:0]  job_period;
  logic [TIMER_BITS-1:0]  job_high;
  logic [TIMER_BITS+15:0] numer;
  logic [TIMER_BITS+15:0] period_ext;
  logic                   saturate;

  logic [TIMER_BITS-1:0] divisor;
  logic [TIMER_BITS-1:0] rem;
  logic [15:0]           lo_bits;
  logic [15:0]           quo;
  logic [CNT_BITS-1:0]   cnt;
  logic [15:0]           ticks;
  logic                  err;

  logic [TIMER_BITS+1:0] trial;
  logic                  fits;
  logic                  out_load;

  assign job_period = pop_data[2*TIMER_BITS-1:TIMER_BITS];
  assign job_high   = pop_data[TIMER_BITS-1:0];

  // dividend = high << FRAC_BITS; quotient overflows 16 bits when its top
  // part already reaches the divisor
  assign numer      = {16'b0, job_high} << FRAC_BITS;
  assign period_ext = {16'b0, job_period};
  assign saturate   = (numer[TIMER_BITS+15:16] >= job_period);

  assign pop_ready = (state == S_IDLE);

  // one restoring step
  assign trial = {1'b0, rem, lo_bits[15]} - {2'b0, divisor};
  assign fits  = !trial[TIMER_BITS+1];

  assign out_load = (state == S_DONE) && (!result.valid || result.ready);

  // divider sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (pop_valid) begin
            if (job_period == '0 || saturate) begin
              state <= S_DONE;
            end else begin
              state <= S_DIV;
            end
          end
        end
        S_DIV: begin
          if (cnt == CNT_BITS'(DUTY_BITS - 1)) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // divider datapath
  always_ff @(posedge clk) begin
    if (state == S_IDLE && pop_valid) begin
      divisor <= job_period;
      rem     <= numer[TIMER_BITS+15:16];
      lo_bits <= numer[15:0];
      cnt     <= '0;
      ticks   <= period_ext[15:0];
      err     <= (job_period == '0);
      quo     <= (job_period == '0 || saturate) ? DUTY_MAX : '0;
    end else if (state == S_DIV) begin
      rem     <= fits ? trial[TIMER_BITS-1:0] : {rem[TIMER_BITS-2:0], lo_bits[15]};
      lo_bits <= {lo_bits[14:0], 1'b0};
      quo     <= {quo[14:0], fits};
      cnt     <= cnt + 1'b1;
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (out_load) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      result.duty_fraction <= quo;
      result.period_ticks  <= ticks;
      result.divide_error  <= err;
    end
  end

endmodule

// ===== src/pwm_duty_cycle_capture_core.sv =====
// ----------------------------------------------------------------------------
// PWM duty-cycle capture core
// Measures PWM duty cycle from down-counter edge timestamps.
//
//   channel   dir   word fields
//   capture   in    capture_time[15:0]
//   result    out   duty_fraction[15:0], period_ticks[15:0], divide_error
//
// A falling-edge word is always accepted and gives no result. A rising-edge
// word gives one result after the divider picks it up: the job is loaded,
// the bit-serial restoring divider runs, and the result is transferred
// into the output register. Zero-period and saturated cases skip the divider.
// A two-entry job queue lets rising edges arrive while the divider is busy
// or a result waits. Reset (rst, synchronous) empties the queue and restores
// the edge phase and timestamps.
// ----------------------------------------------------------------------------
module pwm_duty_cycle_capture_core
  import pdc_pkg::*;
#(
  parameter int FRAC_BITS  = FRAC_BITS_DEF,
  parameter int TIMER_BITS = TIMER_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  pdc_in_if.sink    capture,
  pdc_out_if.source result
);

  logic                    push_valid;
  logic [2*TIMER_BITS-1:0] push_data;
  logic                    push_ready;
  logic                    pop_valid;
  logic [2*TIMER_BITS-1:0] pop_data;
  logic                    pop_ready;

  // edge classification and timestamps
  pdc_front #(
    .TIMER_BITS (TIMER_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .capture    (capture),
    .push_valid (push_valid),
    .push_data  (push_data),
    .push_ready (push_ready)
  );

  // job queue
  pdc_queue #(
    .WIDTH (2 * TIMER_BITS),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_data  (push_data),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_data   (pop_data),
    .pop_ready  (pop_ready)
  );

  // divider and result register
  pdc_back #(
    .FRAC_BITS  (FRAC_BITS),
    .TIMER_BITS (TIMER_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_data  (pop_data),
    .pop_ready (pop_ready),
    .result    (result)
  );

endmodule
